>>> rtl/core/nca_pkg.sv
// shared constants for the negacyclic automorphism permute block
package nca_pkg;

  localparam int INDEX_W     = 12;
  localparam int COEFF_W     = 64;
  localparam int KINV_W      = 13;
  localparam int FIRST_W     = 2;
  localparam int COUNT_W     = 3;
  localparam int IO_LANES    = 4;
  localparam int CFG_INDEX_W = 3;

  localparam int RING_SIZE_DEFAULT = 4096;
  localparam int LANES_DEFAULT     = 4;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_POWER = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_LIMB    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LIMBS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_0     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_1     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_2     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_3     = 3'd6;

  // reset values of the configuration registers
  localparam logic [KINV_W-1:0]  INVERSE_POWER_RESET = 13'd1;
  localparam logic [FIRST_W-1:0] FIRST_LIMB_RESET    = 2'd0;
  localparam logic [COUNT_W-1:0] ACTIVE_LIMBS_RESET  = 3'd4;
  localparam logic [COEFF_W-1:0] MODULUS_RESET       = 64'd2;

  typedef logic [IO_LANES-1:0][COEFF_W-1:0] lane_word_t;
  typedef logic [IO_LANES-1:0]              lane_mask_t;

endpackage

>>> rtl/core/negacyclic_automorphism_permute.sv
// top level: coefficient store with negacyclic automorphism read-out
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_stall  | operation, index, coeff_0..coeff_3
//  out     | output    | out_valid / out_stall| out_0..out_3, negated
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat per cycle on the input while no result is held; a read beat yields its
// result through the input register, the ram read and the negate into the output register.
// the three stages advance together; a stalled result holds the whole pipe.
// one ram per lane, written and read once per cycle, sets the rate.
// reset clears the pipe valids and the configuration registers; the store is not cleared.
module negacyclic_automorphism_permute #(
  parameter int RING_SIZE = nca_pkg::RING_SIZE_DEFAULT,
  parameter int LANES     = nca_pkg::LANES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [nca_pkg::INDEX_W-1:0]       index,
  input  logic [nca_pkg::COEFF_W-1:0]       coeff_0,
  input  logic [nca_pkg::COEFF_W-1:0]       coeff_1,
  input  logic [nca_pkg::COEFF_W-1:0]       coeff_2,
  input  logic [nca_pkg::COEFF_W-1:0]       coeff_3,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nca_pkg::COEFF_W-1:0]       out_0,
  output logic [nca_pkg::COEFF_W-1:0]       out_1,
  output logic [nca_pkg::COEFF_W-1:0]       out_2,
  output logic [nca_pkg::COEFF_W-1:0]       out_3,
  output logic                              negated,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nca_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [nca_pkg::COEFF_W-1:0]       cfg_data
);

  localparam int AW  = $clog2(RING_SIZE);
  localparam int EW  = (AW > nca_pkg::INDEX_W) ? AW : nca_pkg::INDEX_W;
  localparam int KW  = (AW + 1 > nca_pkg::KINV_W) ? AW + 1 : nca_pkg::KINV_W;
  localparam int NL  = (LANES < nca_pkg::IO_LANES) ? LANES : nca_pkg::IO_LANES;
  localparam int SW  = nca_pkg::COUNT_W + 1;

  // configuration registers
  logic [nca_pkg::KINV_W-1:0]  inverse_power;
  logic [nca_pkg::FIRST_W-1:0] first_limb;
  logic [nca_pkg::COUNT_W-1:0] active_limbs;
  nca_pkg::lane_word_t         modulus;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_power <= nca_pkg::INVERSE_POWER_RESET;
      first_limb    <= nca_pkg::FIRST_LIMB_RESET;
      active_limbs  <= nca_pkg::ACTIVE_LIMBS_RESET;
      for (int l = 0; l < nca_pkg::IO_LANES; l++) begin
        modulus[l] <= nca_pkg::MODULUS_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nca_pkg::REG_INVERSE_POWER: inverse_power <= cfg_data[nca_pkg::KINV_W-1:0];
        nca_pkg::REG_FIRST_LIMB:    first_limb    <= cfg_data[nca_pkg::FIRST_W-1:0];
        nca_pkg::REG_ACTIVE_LIMBS:  active_limbs  <= cfg_data[nca_pkg::COUNT_W-1:0];
        nca_pkg::REG_MODULUS_0:     modulus[0]    <= cfg_data;
        nca_pkg::REG_MODULUS_1:     modulus[1]    <= cfg_data;
        nca_pkg::REG_MODULUS_2:     modulus[2]    <= cfg_data;
        nca_pkg::REG_MODULUS_3:     modulus[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // active lane window
  logic [SW-1:0]       window_end;
  nca_pkg::lane_mask_t lane_act;

  always_comb begin
    window_end = SW'(first_limb) + SW'(active_limbs);
    for (int l = 0; l < nca_pkg::IO_LANES; l++) begin
      lane_act[l] = (l < NL) && (SW'(l) >= SW'(first_limb)) && (SW'(l) < window_end);
    end
  end

  // pipe advances unless a finished result is held
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic                s1_valid;
  logic                s1_op;
  logic [AW-1:0]       s1_addr;
  nca_pkg::lane_word_t s1_coeff;
  logic [EW-1:0]       index_ext;

  assign index_ext = EW'(index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op       <= operation;
      s1_addr     <= index_ext[AW-1:0];
      s1_coeff[0] <= coeff_0;
      s1_coeff[1] <= coeff_1;
      s1_coeff[2] <= coeff_2;
      s1_coeff[3] <= coeff_3;
    end
  end

  // source index r = (o * kinv) mod 2N
  logic [KW-1:0] kinv_ext;
  logic [AW:0]   src_r;

  assign kinv_ext = KW'(inverse_power);
  assign src_r    = {1'b0, s1_addr} * kinv_ext[AW:0];

  logic s1_load;
  assign s1_load = s1_valid && (s1_op == nca_pkg::OP_LOAD);

  // one ram per stored lane
  nca_pkg::lane_word_t rd_word;

  for (genvar l = 0; l < nca_pkg::IO_LANES; l++) begin : g_lane
    if (l < NL) begin : g_mem
      nca_ram #(
        .WIDTH (nca_pkg::COEFF_W),
        .DEPTH (RING_SIZE)
      ) u_ram (
        .clk     (clk),
        .wr_en   (adv && s1_load && lane_act[l]),
        .wr_addr (s1_addr),
        .wr_data (s1_coeff[l]),
        .rd_en   (adv),
        .rd_addr (src_r[AW-1:0]),
        .rd_data (rd_word[l])
      );
    end else begin : g_none
      assign rd_word[l] = '0;
    end
  end

  // stage 2: ram data
  logic                s2_valid;
  logic                s2_neg;
  nca_pkg::lane_mask_t s2_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_op == nca_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_neg <= src_r[AW];
      s2_act <= lane_act;
    end
  end

  // negate modulo the lane modulus, zero stays zero; inactive lanes give zero
  nca_pkg::lane_word_t res_next;

  always_comb begin
    for (int l = 0; l < nca_pkg::IO_LANES; l++) begin
      if (!s2_act[l]) begin
        res_next[l] = '0;
      end else if (s2_neg && (rd_word[l] != '0)) begin
        res_next[l] = modulus[l] - rd_word[l];
      end else begin
        res_next[l] = rd_word[l];
      end
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_0   <= res_next[0];
      out_1   <= res_next[1];
      out_2   <= res_next[2];
      out_3   <= res_next[3];
      negated <= s2_neg;
    end
  end

`ifndef SYNTHESIS
  // a load beat never turns into a result
  assert property (@(posedge clk) disable iff (rst)
    (s1_load && adv) |=> !s2_valid)
    else $error("load beat reached the read data stage");

  // ram read data holds while the pipe is held
  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !adv) |=> $stable(rd_word))
    else $error("ram read data changed during a stall");

  // input is only held back by a held result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");
`endif

endmodule

>>> rtl/core/nca_ram.sv
// generic single-write, single-read ram with registered read data
module nca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for negacyclic_automorphism_permute with a lane-accurate predictor
`timescale 1ns / 1ps

module tb;

  localparam int RING        = nca_pkg::RING_SIZE_DEFAULT;
  localparam int IDX_W       = nca_pkg::INDEX_W;
  localparam int PHASES      = 10;
  localparam int BEATS_PER   = 95;
  localparam int DRAIN       = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [nca_pkg::COEFF_W-1:0] lane [nca_pkg::IO_LANES];
    logic                        neg;
  } permuted_t;

  class permute_checker;
    bit [nca_pkg::COEFF_W-1:0] coeff_mem [RING][nca_pkg::IO_LANES];
    bit [nca_pkg::KINV_W-1:0]  kinv;
    bit [nca_pkg::FIRST_W-1:0] first;
    bit [nca_pkg::COUNT_W-1:0] count;
    bit [nca_pkg::COEFF_W-1:0] modq [nca_pkg::IO_LANES];
    permuted_t                 permuted_due [$];
    int errors, n_loads, n_reads, n_neg;

    function new();
      kinv  = nca_pkg::INVERSE_POWER_RESET;
      first = nca_pkg::FIRST_LIMB_RESET;
      count = nca_pkg::ACTIVE_LIMBS_RESET;
      foreach (modq[l]) modq[l] = nca_pkg::MODULUS_RESET;
    endfunction

    function void set_reg(logic [nca_pkg::CFG_INDEX_W-1:0] ri,
                          logic [nca_pkg::COEFF_W-1:0] data);
      case (ri)
        nca_pkg::REG_INVERSE_POWER: kinv = data[nca_pkg::KINV_W-1:0];
        nca_pkg::REG_FIRST_LIMB:    first = data[nca_pkg::FIRST_W-1:0];
        nca_pkg::REG_ACTIVE_LIMBS:  count = data[nca_pkg::COUNT_W-1:0];
        nca_pkg::REG_MODULUS_0:     modq[0] = data;
        nca_pkg::REG_MODULUS_1:     modq[1] = data;
        nca_pkg::REG_MODULUS_2:     modq[2] = data;
        nca_pkg::REG_MODULUS_3:     modq[3] = data;
        default: ;
      endcase
    endfunction

    function bit [nca_pkg::IO_LANES-1:0] active_mask();
      bit [nca_pkg::IO_LANES-1:0] m;
      for (int l = 0; l < nca_pkg::IO_LANES; l++)
        m[l] = (l >= int'(first)) && (l < int'(first) + int'(count));
      return m;
    endfunction

    // r = o * kinv mod 2N; bit INDEX_W of r says the source wrapped
    function void permute_index(input bit [nca_pkg::INDEX_W-1:0] o,
                                output bit [nca_pkg::INDEX_W-1:0] src, output bit neg);
      bit [nca_pkg::INDEX_W+nca_pkg::KINV_W-1:0] prod;
      prod = {{nca_pkg::KINV_W{1'b0}}, o} * {{nca_pkg::INDEX_W{1'b0}}, kinv};
      neg  = prod[nca_pkg::INDEX_W];
      src  = prod[nca_pkg::INDEX_W-1:0];
    endfunction

    function void take_input(logic op, logic [nca_pkg::INDEX_W-1:0] idx,
                             logic [nca_pkg::COEFF_W-1:0] c0, logic [nca_pkg::COEFF_W-1:0] c1,
                             logic [nca_pkg::COEFF_W-1:0] c2, logic [nca_pkg::COEFF_W-1:0] c3);
      bit [nca_pkg::COEFF_W-1:0]  c [nca_pkg::IO_LANES];
      bit [nca_pkg::IO_LANES-1:0] m;
      bit [nca_pkg::INDEX_W-1:0]  src;
      bit                         neg;
      bit [nca_pkg::COEFF_W-1:0]  v;
      permuted_t                  want;
      c = '{c0, c1, c2, c3};
      m = active_mask();
      if (op == nca_pkg::OP_LOAD) begin
        for (int l = 0; l < nca_pkg::IO_LANES; l++)
          if (m[l]) coeff_mem[idx][l] = c[l];
        n_loads++;
      end else begin
        permute_index(idx, src, neg);
        for (int l = 0; l < nca_pkg::IO_LANES; l++) begin
          v = '0;
          if (m[l]) begin
            v = coeff_mem[src][l];
            if (neg && v != '0) v = modq[l] - v;
          end
          want.lane[l] = v;
        end
        want.neg = neg;
        permuted_due.push_back(want);
        n_reads++;
        n_neg += int'(neg);
      end
    endfunction

    task report_mismatch(string what, logic [nca_pkg::COEFF_W-1:0] got,
                         logic [nca_pkg::COEFF_W-1:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task check_output(logic [nca_pkg::COEFF_W-1:0] o0, logic [nca_pkg::COEFF_W-1:0] o1,
                      logic [nca_pkg::COEFF_W-1:0] o2, logic [nca_pkg::COEFF_W-1:0] o3,
                      logic ng);
      logic [nca_pkg::COEFF_W-1:0] got [nca_pkg::IO_LANES];
      permuted_t                   want;
      got = '{o0, o1, o2, o3};
      if (permuted_due.size() == 0) begin
        report_mismatch("result with none pending, out_0", o0, '0);
        return;
      end
      want = permuted_due.pop_front();
      for (int l = 0; l < nca_pkg::IO_LANES; l++)
        if (got[l] !== want.lane[l])
          report_mismatch($sformatf("out_%0d", l), got[l], want.lane[l]);
      if (ng !== want.neg) report_mismatch("negated", 64'(ng), 64'(want.neg));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            operation = nca_pkg::OP_LOAD;
  logic [nca_pkg::INDEX_W-1:0]     index = '0;
  logic [nca_pkg::COEFF_W-1:0]     coeff_0 = '0, coeff_1 = '0, coeff_2 = '0, coeff_3 = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [nca_pkg::COEFF_W-1:0]     out_0, out_1, out_2, out_3;
  logic                            negated;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [nca_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [nca_pkg::COEFF_W-1:0]     cfg_data = '0;

  permute_checker             sb = new();
  bit [nca_pkg::IO_LANES-1:0] loaded [RING];
  int                         idle_pct = 0;
  int                         stall_pct = 0;
  int                         cycle_count = 0;

  negacyclic_automorphism_permute dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .index(index),
    .coeff_0(coeff_0), .coeff_1(coeff_1), .coeff_2(coeff_2), .coeff_3(coeff_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3), .negated(negated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.take_input(operation, index, coeff_0, coeff_1, coeff_2, coeff_3);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_output(out_0, out_1, out_2, out_3, negated);
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("negacyclic_automorphism_permute test failed");
    $finish;
  end

  function automatic logic [nca_pkg::COEFF_W-1:0] pick_coeff(int l);
    logic [nca_pkg::COEFF_W-1:0] q;
    q = sb.modq[l];
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return q;
      3: return q - 1;
      4: return 64'd1;
      5: return {$urandom, $urandom} % q;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [nca_pkg::COEFF_W-1:0] pick_modulus();
    logic [nca_pkg::COEFF_W-1:0] q;
    case ($urandom_range(3))
      0: q = 64'd2;
      1: q = '1;
      default: q = {$urandom, $urandom};
    endcase
    if (q < 64'd2) q = 64'd2;
    return q;
  endfunction

  // beat waits out a random sender gap, then holds until accepted
  task automatic send_beat(logic op, logic [nca_pkg::INDEX_W-1:0] idx,
                           logic [nca_pkg::COEFF_W-1:0] c0, logic [nca_pkg::COEFF_W-1:0] c1,
                           logic [nca_pkg::COEFF_W-1:0] c2, logic [nca_pkg::COEFF_W-1:0] c3);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    index     <= idx;
    coeff_0   <= c0;
    coeff_1   <= c1;
    coeff_2   <= c2;
    coeff_3   <= c3;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_beat(logic [nca_pkg::INDEX_W-1:0] idx,
                           logic [nca_pkg::COEFF_W-1:0] c0, logic [nca_pkg::COEFF_W-1:0] c1,
                           logic [nca_pkg::COEFF_W-1:0] c2, logic [nca_pkg::COEFF_W-1:0] c3);
    loaded[idx] |= sb.active_mask();
    send_beat(nca_pkg::OP_LOAD, idx, c0, c1, c2, c3);
  endtask

  task automatic load_random(logic [nca_pkg::INDEX_W-1:0] idx);
    load_beat(idx, pick_coeff(0), pick_coeff(1), pick_coeff(2), pick_coeff(3));
  endtask

  // never read an active lane that was not loaded: fill the source entry first
  task automatic read_beat(logic [nca_pkg::INDEX_W-1:0] o);
    bit [nca_pkg::INDEX_W-1:0]  src;
    bit                         neg;
    bit [nca_pkg::IO_LANES-1:0] need;
    sb.permute_index(o, src, neg);
    need = sb.active_mask();
    if ((loaded[src] & need) != need) load_random(src);
    send_beat(nca_pkg::OP_READ, o, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic settle();
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.permuted_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic program_regs(logic [nca_pkg::COEFF_W-1:0] kinv,
                              logic [nca_pkg::COEFF_W-1:0] first,
                              logic [nca_pkg::COEFF_W-1:0] count,
                              logic [nca_pkg::COEFF_W-1:0] q0,
                              logic [nca_pkg::COEFF_W-1:0] q1,
                              logic [nca_pkg::COEFF_W-1:0] q2,
                              logic [nca_pkg::COEFF_W-1:0] q3);
    logic [nca_pkg::CFG_INDEX_W-1:0] ri [7];
    logic [nca_pkg::COEFF_W-1:0]     vals [7];
    ri   = '{nca_pkg::REG_INVERSE_POWER, nca_pkg::REG_FIRST_LIMB, nca_pkg::REG_ACTIVE_LIMBS,
             nca_pkg::REG_MODULUS_0, nca_pkg::REG_MODULUS_1, nca_pkg::REG_MODULUS_2,
             nca_pkg::REG_MODULUS_3};
    vals = '{kinv, first, count, q0, q1, q2, q3};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= ri[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(ri[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [nca_pkg::COEFF_W-1:0] kinv;
    logic [nca_pkg::COEFF_W-1:0] first;
    logic [nca_pkg::COEFF_W-1:0] count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: identity permutation, no negation
    load_beat(12'd0, 64'd0, 64'd1, '1, 64'h8000_0000_0000_0000);
    load_beat(12'd4095, '1, '1, '1, '1);
    read_beat(12'd0);
    read_beat(12'd4095);
    read_beat(12'd5);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: kinv = 64'd8191;
        1: kinv = 64'd1;
        2: kinv = 64'd0;
        3: kinv = 64'd4096;
        4: kinv = 64'd4097;
        5: kinv = 64'd8191;
        6: kinv = 64'd2;
        default: kinv = 64'($urandom_range(8191));
      endcase
      first = 64'(p % 4);
      count = 64'((p * 3) % 5);
      if (p == 0) begin
        program_regs(kinv, 64'd0, 64'd4, '1, 64'd2, 64'd1000003, 64'h8000_0000_0000_0001);
      end else begin
        program_regs(kinv, first, count, pick_modulus(), pick_modulus(), pick_modulus(),
                     pick_modulus());
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase

      if (p == 0) begin
        // kinv = -1: every nonzero output index wraps and negates
        load_beat(12'd0, '1, 64'd1, 64'd0, 64'h8000_0000_0000_0000);
        load_beat(12'd4095, 64'd0, 64'd0, 64'd0, 64'd0);
        load_beat(12'd1, 64'd1, 64'd5, 64'd999, 64'h7fff_ffff_ffff_ffff);
        load_random(12'd2048);
        read_beat(12'd0);
        read_beat(12'd1);
        read_beat(12'd4095);
        read_beat(12'd2048);
        read_beat(12'd2047);
      end

      for (int n = 0; n < BEATS_PER; n++) begin
        case ($urandom_range(9))
          0: read_beat('1);
          1, 2, 3, 4: read_beat(IDX_W'($urandom_range(4095)));
          5: load_random('0);
          default: load_random(IDX_W'($urandom_range(4095)));
        endcase
      end
      settle();
    end

    $display("%0d loads and %0d reads checked, %0d of them wrapped and negated,",
             sb.n_loads, sb.n_reads, sb.n_neg);
    $display("over %0d register settings with sender gaps and output stalls mixed in",
             PHASES + 1);
    if (sb.errors == 0) begin
      $display("negacyclic_automorphism_permute test passed");
    end else begin
      $display("negacyclic_automorphism_permute test failed");
    end
    $finish;
  end

endmodule
